// ===== rtl/ssal_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ssal_pkg
// Shared constants for the shortest-run-sum-at-least unit.
// ----------------------------------------------------------------------------
package ssal_pkg;

	// Default sequence capacity in elements.
	localparam int unsigned MAX_ITEMS_DEF = 1024;

	// Width of one sequence element and of the threshold register.
	localparam int unsigned VALUE_W = 32;

	// Reset value of the threshold register.
	localparam logic signed [VALUE_W-1:0] THRESHOLD_RST = 32'sd1;

endpackage

// ===== rtl/shortest_subarray_sum_at_least_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// shortest_subarray_sum_at_least_unit
// Finds the shortest contiguous run of a signed sequence whose sum reaches a
// programmable threshold, using a monotonic deque of prefix sums in RAM.
// ----------------------------------------------------------------------------
// An element is accepted in the idle state, then pops deque entries from the
// front and back before its prefix is pushed; an entry is popped at most once,
// and the read-compare-update loop on the deque RAM takes no new element until
// the last is pushed. The result word is loaded once the final element is done
// and the output register is free; the next word is taken in the cycle after.
// Reset clears the sequence state and loads threshold 1; the RAM is not cleared.
module shortest_subarray_sum_at_least_unit
	import ssal_pkg::*;
#(
	parameter int unsigned MAX_ITEMS = MAX_ITEMS_DEF,
	localparam int unsigned CW = $clog2(MAX_ITEMS + 1),
	localparam int unsigned PW = VALUE_W + $clog2(MAX_ITEMS),
	localparam int unsigned AW = (CW > 0) ? CW : 1,
	localparam int unsigned TW = $clog2(MAX_ITEMS + 2),
	localparam int unsigned DEPTH = MAX_ITEMS + 1
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      threshold_we,
	input  logic signed [VALUE_W-1:0] threshold_data,
	input  logic                      in_valid,
	output logic                      in_ready,
	input  logic signed [VALUE_W-1:0] value,
	input  logic                      last,
	output logic                      out_valid,
	input  logic                      out_ready,
	output logic                      found,
	output logic [CW-1:0]             length,
	output logic                      overflow
);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_FRONT,
		ST_BACK,
		ST_DONE
	} state_t;

	typedef struct packed {
		logic signed [PW-1:0] prefix;
		logic [CW-1:0]        pos;
	} entry_t;

	state_t state_q, state_d;

	logic signed [VALUE_W-1:0] threshold_q;
	logic signed [PW-1:0]      prefix_q, prefix_d;
	logic [CW-1:0]             count_q, count_d;
	logic [CW-1:0]             best_q, best_d;
	logic [TW-1:0]             head_q, head_d;
	logic [TW-1:0]             tail_q, tail_d;
	logic [TW-1:0]             tail_m1;
	logic                      ovf_q, ovf_d;
	logic                      last_q, last_d;
	logic                      zero_q, zero_d;

	logic                      out_valid_q;
	logic                      found_q;
	logic [CW-1:0]             length_q;
	logic                      overflow_q;

	// Deque RAM: one write port, two registered read ports.
	entry_t                    mem [DEPTH];
	entry_t                    rd_a_raw, rd_b_raw;
	entry_t                    rd_a, rd_b;
	entry_t                    wdata, wdata_q;
	logic                      we;
	logic [AW-1:0]             addr_a, addr_b, waddr;
	logic                      fwd_a_q, fwd_b_q, zr_a_q, zr_b_q;

	logic signed [PW:0]        diff;
	logic                      front_hit, back_hit;
	logic [CW-1:0]             run_len;
	logic                      out_load;

	assign in_ready  = (state_q == ST_IDLE);
	assign out_valid = out_valid_q;
	assign found     = found_q;
	assign length    = length_q;
	assign overflow  = overflow_q;

	// Read data with write forwarding and the empty-prefix override of slot 0.
	always_comb begin
		if (fwd_a_q) begin
			rd_a = wdata_q;
		end else if (zr_a_q) begin
			rd_a = '0;
		end else begin
			rd_a = rd_a_raw;
		end
		if (fwd_b_q) begin
			rd_b = wdata_q;
		end else if (zr_b_q) begin
			rd_b = '0;
		end else begin
			rd_b = rd_b_raw;
		end
	end

	assign diff      = (PW + 1)'(prefix_q) - (PW + 1)'(rd_a.prefix);
	assign front_hit = (head_q < tail_q) && (diff >= (PW + 1)'(threshold_q));
	assign back_hit  = (tail_q > head_q) && (rd_b.prefix >= prefix_q);
	assign run_len   = count_q - rd_a.pos;
	assign out_load  = (state_q == ST_DONE) && (!out_valid_q || out_ready);

	always_comb begin
		state_d  = state_q;
		prefix_d = prefix_q;
		count_d  = count_q;
		best_d   = best_q;
		head_d   = head_q;
		tail_d   = tail_q;
		ovf_d    = ovf_q;
		last_d   = last_q;
		zero_d   = zero_q;
		we       = 1'b0;
		wdata    = '{prefix: prefix_q, pos: count_q};
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					last_d = last;
					if (count_q == CW'(MAX_ITEMS)) begin
						ovf_d = 1'b1;
						if (last) begin
							state_d = ST_DONE;
						end
					end else begin
						prefix_d = prefix_q + PW'(value);
						count_d  = count_q + 1'b1;
						state_d  = ST_FRONT;
					end
				end
			end
			ST_FRONT: begin
				if (front_hit) begin
					if (best_q == '0 || run_len < best_q) begin
						best_d = run_len;
					end
					head_d = head_q + 1'b1;
				end else begin
					state_d = ST_BACK;
				end
			end
			ST_BACK: begin
				if (back_hit) begin
					tail_d = tail_q - 1'b1;
				end else begin
					we     = 1'b1;
					tail_d = tail_q + 1'b1;
					if (tail_q == '0) begin
						zero_d = 1'b0;
					end
					state_d = last_q ? ST_DONE : ST_IDLE;
				end
			end
			ST_DONE: begin
				if (out_load) begin
					prefix_d = '0;
					count_d  = '0;
					best_d   = '0;
					head_d   = '0;
					tail_d   = TW'(1);
					ovf_d    = 1'b0;
					zero_d   = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// Reads follow the next head and the entry just below the next tail, so the
	// data for the current pointers is registered together with the pointers.
	assign tail_m1 = tail_d - 1'b1;
	assign addr_a  = head_d[AW-1:0];
	assign addr_b  = tail_m1[AW-1:0];
	assign waddr   = tail_q[AW-1:0];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rd_a_raw <= mem[addr_a];
		rd_b_raw <= mem[addr_b];
		wdata_q  <= wdata;
		fwd_a_q  <= we && (addr_a == waddr);
		fwd_b_q  <= we && (addr_b == waddr);
		zr_a_q   <= zero_d && (addr_a == '0);
		zr_b_q   <= zero_d && (addr_b == '0);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			threshold_q <= THRESHOLD_RST;
			prefix_q    <= '0;
			count_q     <= '0;
			best_q      <= '0;
			head_q      <= '0;
			tail_q      <= TW'(1);
			ovf_q       <= 1'b0;
			last_q      <= 1'b0;
			zero_q      <= 1'b1;
			out_valid_q <= 1'b0;
			found_q     <= 1'b0;
			length_q    <= '0;
			overflow_q  <= 1'b0;
		end else begin
			state_q  <= state_d;
			prefix_q <= prefix_d;
			count_q  <= count_d;
			best_q   <= best_d;
			head_q   <= head_d;
			tail_q   <= tail_d;
			ovf_q    <= ovf_d;
			last_q   <= last_d;
			zero_q   <= zero_d;
			if (threshold_we) begin
				threshold_q <= threshold_data;
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
				found_q     <= !ovf_q && (best_q != '0);
				length_q    <= ovf_q ? '0 : best_q;
				overflow_q  <= ovf_q;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule
